@@ src/rgb_block_to_ypbpr_assert.svh @@
// Assertion macros used by the block's top-level RTL.
`ifndef RGB_BLOCK_TO_YPBPR_ASSERT_SVH
`define RGB_BLOCK_TO_YPBPR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RBTY_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_block_to_ypbpr: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RBTY_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_block_to_ypbpr: assertion failed");

`endif

@@ src/rbty_pkg.sv @@
package rbty_pkg;

	localparam int FRAC_BITS_DEF = 15;
	localparam int FIELD_W = 16;
	localparam int COEF_W = 21;
	localparam int PROD_W = 38;
	localparam int MAG_W = 36;
	localparam int DEN_W = 36;
	localparam int COEF_SCALE = 1000000;
	localparam logic [FIELD_W-1:0] SAMPLE_MAX_RESET = 16'd255;

	// rows: luma, blue difference, red difference; columns: R, G, B (millionths)
	localparam logic signed [COEF_W-1:0] COEF_TABLE [3][3] = '{
		'{ 21'sd299000,  21'sd587000,  21'sd114000},
		'{-21'sd168736, -21'sd331264,  21'sd500000},
		'{ 21'sd500000, -21'sd418688, -21'sd81312}
	};

	typedef struct packed {
		logic [FIELD_W-1:0] red;
		logic [FIELD_W-1:0] green;
		logic [FIELD_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [FIELD_W-1:0]        luma;
		logic signed [FIELD_W-1:0] chroma_blue;
		logic signed [FIELD_W-1:0] chroma_red;
	} ypp_t;

	typedef struct packed {
		logic [FIELD_W-1:0] red_a;
		logic [FIELD_W-1:0] green_a;
		logic [FIELD_W-1:0] blue_a;
		logic [FIELD_W-1:0] red_b;
		logic [FIELD_W-1:0] green_b;
		logic [FIELD_W-1:0] blue_b;
		logic [FIELD_W-1:0] red_c;
		logic [FIELD_W-1:0] green_c;
		logic [FIELD_W-1:0] blue_c;
		logic [FIELD_W-1:0] red_d;
		logic [FIELD_W-1:0] green_d;
		logic [FIELD_W-1:0] blue_d;
	} pix_word_t;

	typedef struct packed {
		logic [FIELD_W-1:0]        luma_a;
		logic signed [FIELD_W-1:0] chroma_blue_a;
		logic signed [FIELD_W-1:0] chroma_red_a;
		logic [FIELD_W-1:0]        luma_b;
		logic signed [FIELD_W-1:0] chroma_blue_b;
		logic signed [FIELD_W-1:0] chroma_red_b;
		logic [FIELD_W-1:0]        luma_c;
		logic signed [FIELD_W-1:0] chroma_blue_c;
		logic signed [FIELD_W-1:0] chroma_red_c;
		logic [FIELD_W-1:0]        luma_d;
		logic signed [FIELD_W-1:0] chroma_blue_d;
		logic signed [FIELD_W-1:0] chroma_red_d;
	} ypp_word_t;

endpackage

@@ src/rbty_stream_if.sv @@
interface rbty_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

@@ src/rbty_mix.sv @@
module rbty_mix #(
	parameter int FRAC_BITS = rbty_pkg::FRAC_BITS_DEF,
	parameter int ROW = 0
) (
	input  logic                           clk,
	input  logic [3:0]                     adv,
	input  logic [rbty_pkg::DEN_W-1:0]     den,
	input  rbty_pkg::rgb_t                 pix,
	output logic [FRAC_BITS+rbty_pkg::MAG_W+1:0] num,
	output logic                           neg
);
	localparam int N_W = FRAC_BITS + rbty_pkg::MAG_W + 2;
	localparam int PW = rbty_pkg::PROD_W;

	logic signed [PW-1:0] smp [3];
	logic signed [PW-1:0] cf [3];
	logic signed [PW-1:0] prod_s1 [3];
	logic signed [PW-1:0] sum_s2;
	logic signed [PW-1:0] abs_v;
	logic [rbty_pkg::MAG_W-1:0] mag_s3;
	logic neg_s3;
	logic neg_s4;
	logic [N_W-1:0] num_s4;

	assign smp[0] = PW'({1'b0, pix.red});
	assign smp[1] = PW'({1'b0, pix.green});
	assign smp[2] = PW'({1'b0, pix.blue});

	for (genvar k = 0; k < 3; k++) begin : g_cf
		assign cf[k] = PW'(rbty_pkg::COEF_TABLE[ROW][k]);
	end

	assign abs_v = sum_s2[PW-1] ? -sum_s2 : sum_s2;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k] <= smp[k] * cf[k];
			end
		end
		if (adv[1]) begin
			sum_s2 <= prod_s1[0] + prod_s1[1] + prod_s1[2];
		end
		if (adv[2]) begin
			neg_s3 <= sum_s2[PW-1];
			mag_s3 <= abs_v[rbty_pkg::MAG_W-1:0];
		end
		if (adv[3]) begin
			// 2*|num|*2^F + den: rounding bias folded into the dividend
			num_s4 <= (N_W'(mag_s3) << (FRAC_BITS + 1)) + N_W'(den);
			neg_s4 <= neg_s3;
		end
	end

	assign num = num_s4;
	assign neg = neg_s4;
endmodule

@@ src/rbty_div.sv @@
module rbty_div #(
	parameter int FRAC_BITS = rbty_pkg::FRAC_BITS_DEF,
	parameter bit IS_LUMA = 1'b1
) (
	input  logic                              clk,
	input  logic [FRAC_BITS+3:0]              adv,
	input  logic [rbty_pkg::DEN_W-1:0]        den,
	input  logic [FRAC_BITS+rbty_pkg::MAG_W+1:0] num,
	input  logic                              neg,
	output logic [rbty_pkg::FIELD_W-1:0]      res
);
	localparam int QW = FRAC_BITS + 2;
	localparam int N_W = FRAC_BITS + rbty_pkg::MAG_W + 2;
	localparam int D_W = rbty_pkg::DEN_W + 1;
	localparam int FW = rbty_pkg::FIELD_W;
	localparam int RW = (QW > FW) ? QW + 1 : FW + 1;
	localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] HALF = QW'(1) << (FRAC_BITS - 1);

	logic [D_W-1:0] dvs;
	logic [N_W:0]   ovf_lim;
	logic [N_W-1:0] rem_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic           sat_s [QW+1];
	logic           neg_s [QW+1];
	logic [QW-1:0]  lim_v;
	logic [QW-1:0]  mag_v;
	logic signed [RW-1:0] val;
	logic [FW-1:0]  clamp_s;

	assign dvs = {den, 1'b0};
	assign ovf_lim = (N_W + 1)'(dvs) << QW;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			sat_s[0] <= {1'b0, num} >= ovf_lim;
			neg_s[0] <= neg;
		end
	end

	// restoring division, one quotient bit per stage, MSB first
	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int B = QW - 1 - j;
		logic [N_W-1:0] sub;
		logic           ge;

		assign sub = N_W'(dvs) << B;
		assign ge = rem_s[j] >= sub;

		always_ff @(posedge clk) begin
			if (adv[j+1]) begin
				rem_s[j+1] <= ge ? rem_s[j] - sub : rem_s[j];
				quo_s[j+1] <= {quo_s[j][QW-2:0], ge};
				sat_s[j+1] <= sat_s[j];
				neg_s[j+1] <= neg_s[j];
			end
		end
	end

	always_comb begin
		lim_v = IS_LUMA ? ONE : HALF;
		mag_v = (sat_s[QW] || quo_s[QW] > lim_v) ? lim_v : quo_s[QW];
		if (IS_LUMA && neg_s[QW]) begin
			val = '0;
		end else if (neg_s[QW]) begin
			val = -RW'(mag_v);
		end else begin
			val = RW'(mag_v);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[QW+1]) begin
			clamp_s <= val[FW-1:0];
		end
	end

	assign res = clamp_s;
endmodule

@@ src/rbty_lane.sv @@
module rbty_lane #(
	parameter int FRAC_BITS = rbty_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic [FRAC_BITS+7:0]       adv,
	input  logic [rbty_pkg::DEN_W-1:0] den,
	input  rbty_pkg::rgb_t             pix,
	output rbty_pkg::ypp_t             res
);
	localparam int N_W = FRAC_BITS + rbty_pkg::MAG_W + 2;

	logic [N_W-1:0]                num_w [3];
	logic                          neg_w [3];
	logic [rbty_pkg::FIELD_W-1:0]  comp [3];

	for (genvar r = 0; r < 3; r++) begin : g_row
		rbty_mix #(
			.FRAC_BITS(FRAC_BITS),
			.ROW(r)
		) u_mix (
			.clk(clk),
			.adv(adv[3:0]),
			.den(den),
			.pix(pix),
			.num(num_w[r]),
			.neg(neg_w[r])
		);

		rbty_div #(
			.FRAC_BITS(FRAC_BITS),
			.IS_LUMA(r == 0)
		) u_div (
			.clk(clk),
			.adv(adv[FRAC_BITS+7:4]),
			.den(den),
			.num(num_w[r]),
			.neg(neg_w[r]),
			.res(comp[r])
		);
	end

	assign res.luma = comp[0];
	assign res.chroma_blue = comp[1];
	assign res.chroma_red = comp[2];
endmodule

@@ src/rgb_block_to_ypbpr.sv @@
// Converts a 2x2 block of RGB pixels to BT.601 luma and blue/red differences
// per pixel, samples scaled against sample_max (0 acts as 1), results rounded
// to nearest with FRAC_BITS fraction bits and clamped. Four pixel lanes run in
// parallel; one block is accepted every cycle while the output is not stalled or
// a stage is empty, and its word leaves a pipeline whose depth is mostly set by
// the pipelined restoring divider, one quotient bit per stage. Stalls on the output
// fill pipeline bubbles before pix.ready drops. Write sample_max only while idle.
module rgb_block_to_ypbpr #(
	parameter int FRAC_BITS = rbty_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbty_pkg::FIELD_W-1:0]  cfg_wdata,
	rbty_stream_if.sink                   pix,
	rbty_stream_if.source                 ypp
);
	localparam int DEPTH = FRAC_BITS + 9;
	localparam int DW = rbty_pkg::DEN_W;

	logic [DW-1:0]        den_q;
	logic [DW-1:0]        den_nx;
	logic [DEPTH-1:0]     vld_q;
	logic [DEPTH-1:0]     vld_in;
	logic [DEPTH-1:0]     rdy;
	rbty_pkg::rgb_t       lane_pix [4];
	rbty_pkg::ypp_t       lane_res [4];
	rbty_pkg::ypp_word_t  res_q;

	// sample_max * 10^6, zero treated as one
	assign den_nx = (cfg_wdata == '0) ? DW'(rbty_pkg::COEF_SCALE)
		: DW'(cfg_wdata) * DW'(rbty_pkg::COEF_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= DW'(rbty_pkg::SAMPLE_MAX_RESET) * DW'(rbty_pkg::COEF_SCALE);
		end else if (cfg_we) begin
			den_q <= den_nx;
		end
	end

	// a stage loads when it or anything after it is empty, or the sink takes
	for (genvar k = 0; k < DEPTH; k++) begin : g_rdy
		assign rdy[k] = ypp.ready || !(&vld_q[DEPTH-1:k]);
	end

	assign vld_in = {vld_q[DEPTH-2:0], pix.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_in & rdy) | (vld_q & ~rdy);
		end
	end

	assign pix.ready = rdy[0];

	assign lane_pix[0] = '{red: pix.word.red_a, green: pix.word.green_a, blue: pix.word.blue_a};
	assign lane_pix[1] = '{red: pix.word.red_b, green: pix.word.green_b, blue: pix.word.blue_b};
	assign lane_pix[2] = '{red: pix.word.red_c, green: pix.word.green_c, blue: pix.word.blue_c};
	assign lane_pix[3] = '{red: pix.word.red_d, green: pix.word.green_d, blue: pix.word.blue_d};

	for (genvar p = 0; p < 4; p++) begin : g_lane
		rbty_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk(clk),
			.adv(rdy[DEPTH-2:0]),
			.den(den_q),
			.pix(lane_pix[p]),
			.res(lane_res[p])
		);
	end

	// merge the four lanes into one output word
	always_ff @(posedge clk) begin
		if (rdy[DEPTH-1]) begin
			res_q.luma_a        <= lane_res[0].luma;
			res_q.chroma_blue_a <= lane_res[0].chroma_blue;
			res_q.chroma_red_a  <= lane_res[0].chroma_red;
			res_q.luma_b        <= lane_res[1].luma;
			res_q.chroma_blue_b <= lane_res[1].chroma_blue;
			res_q.chroma_red_b  <= lane_res[1].chroma_red;
			res_q.luma_c        <= lane_res[2].luma;
			res_q.chroma_blue_c <= lane_res[2].chroma_blue;
			res_q.chroma_red_c  <= lane_res[2].chroma_red;
			res_q.luma_d        <= lane_res[3].luma;
			res_q.chroma_blue_d <= lane_res[3].chroma_blue;
			res_q.chroma_red_d  <= lane_res[3].chroma_red;
		end
	end

	assign ypp.valid = vld_q[DEPTH-1];
	assign ypp.word = res_q;

`include "rgb_block_to_ypbpr_assert.svh"

	`RBTY_ASSERT_NEXT(a_accept_enters, pix.valid && pix.ready, vld_q[0])
	`RBTY_ASSERT_NEXT(a_den_nonzero, cfg_we, den_q != '0)
	`RBTY_ASSERT_NOW(a_luma_bound, ypp.valid, (FRAC_BITS > 15) || (ypp.word.luma_a <= 16'(1 << FRAC_BITS)))
endmodule

@@ sim/rgb_block_to_ypbpr_tb.sv @@
module rgb_block_to_ypbpr_tb;

	localparam int HALF_PERIOD = 6;
	localparam int FRAC = 15;
	localparam int FW = rbty_pkg::FIELD_W;
	localparam longint LUMA_ONE = longint'(1) << FRAC;
	localparam longint CHROMA_HALF = longint'(1) << (FRAC - 1);
	localparam longint unsigned PER_MILLION = 1000000;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	// rows: luma, blue difference, red difference; columns: R, G, B in millionths
	localparam longint MIX [3][3] = '{
		'{ 299000,  587000,  114000},
		'{-168736, -331264,  500000},
		'{ 500000, -418688,  -81312}
	};

	class ypbpr_book;
		rbty_pkg::ypp_word_t ypbpr_due[$];
		logic [FW-1:0] sample_max;
		int mismatches;
		int words_checked;
		string kind_name[3];

		function new();
			sample_max = 16'd255;
			mismatches = 0;
			words_checked = 0;
			kind_name = '{"luma", "chroma_blue", "chroma_red"};
		endfunction

		function void set_max(logic [FW-1:0] v);
			sample_max = v;
		endfunction

		function int pending();
			return ypbpr_due.size();
		endfunction

		function rbty_pkg::ypp_t to_ypbpr(rbty_pkg::rgb_t px);
			longint chan [3];
			longint sum, val, lo, hi;
			longint unsigned den, mag, q;
			bit neg;
			logic [FW-1:0] lane [3];
			chan[0] = px.red;
			chan[1] = px.green;
			chan[2] = px.blue;
			// a zero maximum behaves as one
			den = ((sample_max == '0) ? 64'd1 : 64'(sample_max)) * PER_MILLION;
			for (int k = 0; k < 3; k++) begin
				sum = MIX[k][0] * chan[0] + MIX[k][1] * chan[1]
					+ MIX[k][2] * chan[2];
				neg = sum < 0;
				mag = neg ? -sum : sum;
				q = ((mag << FRAC) * 64'd2 + den) / (den * 64'd2);
				val = neg ? -longint'(q) : longint'(q);
				lo = (k == 0) ? 0 : -CHROMA_HALF;
				hi = (k == 0) ? LUMA_ONE : CHROMA_HALF;
				if (val < lo)
					val = lo;
				else if (val > hi)
					val = hi;
				lane[k] = val[FW-1:0];
			end
			return {lane[0], lane[1], lane[2]};
		endfunction

		function void note_block(rbty_pkg::pix_word_t w);
			rbty_pkg::ypp_word_t e;
			for (int p = 0; p < 4; p++)
				e[(3-p)*48 +: 48] = to_ypbpr(w[(3-p)*48 +: 48]);
			ypbpr_due.push_back(e);
		endfunction

		function void check_block(rbty_pkg::ypp_word_t got);
			rbty_pkg::ypp_word_t want;
			logic [FW-1:0] x, g;
			words_checked++;
			if (ypbpr_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output word 0x%h", got);
				return;
			end
			want = ypbpr_due.pop_front();
			for (int f = 0; f < 12; f++) begin
				x = want[(11-f)*16 +: 16];
				g = got[(11-f)*16 +: 16];
				if (g !== x) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d %s_%c: expected %0d (0x%h), got %0d (0x%h)",
							words_checked, kind_name[f%3], 8'h61 + f/3,
							(f%3 == 0) ? int'(x) : int'($signed(x)), x,
							(f%3 == 0) ? int'(g) : int'($signed(g)), g);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [FW-1:0] cfg_wdata;

	rbty_stream_if #(.word_t(rbty_pkg::pix_word_t)) pix_if ();
	rbty_stream_if #(.word_t(rbty_pkg::ypp_word_t)) ypp_if ();

	rgb_block_to_ypbpr dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix(pix_if),
		.ypp(ypp_if)
	);

	ypbpr_book book = new();

	bit calm = 0;
	bit sender_rests = 1;
	bit hold_req = 0;
	int holds_done = 0;
	int blocks_sent = 0;
	int settings_used = 0;
	int cycles = 0;
	rbty_pkg::pix_word_t dir_q[$];

	bit in_fire, out_fire;
	rbty_pkg::pix_word_t in_word;
	rbty_pkg::ypp_word_t out_word;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// sample between edges, act on the edge
	always @(negedge clk) begin
		in_fire = pix_if.valid && pix_if.ready;
		in_word = pix_if.word;
		out_fire = ypp_if.valid && ypp_if.ready;
		out_word = ypp_if.word;
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (in_fire)
				book.note_block(in_word);
			if (out_fire)
				book.check_block(out_word);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending",
				cycles, book.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		ypp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				ypp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
				holds_done++;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				ypp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				ypp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	function automatic rbty_pkg::rgb_t rgb(logic [FW-1:0] r, logic [FW-1:0] g,
		logic [FW-1:0] b);
		return {r, g, b};
	endfunction

	function automatic rbty_pkg::pix_word_t quad(rbty_pkg::rgb_t a, rbty_pkg::rgb_t b,
		rbty_pkg::rgb_t c, rbty_pkg::rgb_t d);
		return {a, b, c, d};
	endfunction

	function automatic rbty_pkg::pix_word_t flat(logic [FW-1:0] v);
		return quad(rgb(v, v, v), rgb(v, v, v), rgb(v, v, v), rgb(v, v, v));
	endfunction

	function automatic logic [FW-1:0] pick_sample(logic [FW-1:0] top);
		logic [FW-1:0] lim;
		lim = (top == '0) ? 16'd1 : top;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, lim));
			6, 7: return 16'($urandom_range(0, 65535));
			8: return 16'd0;
			default: return $urandom_range(0, 1) ? lim : 16'hFFFF;
		endcase
	endfunction

	function automatic rbty_pkg::pix_word_t random_block(logic [FW-1:0] top);
		rbty_pkg::rgb_t px [4];
		bit grey;
		logic [FW-1:0] v;
		grey = ($urandom_range(0, 4) == 0);
		for (int p = 0; p < 4; p++) begin
			if (grey) begin
				v = pick_sample(top);
				px[p] = rgb(v, v, v);
			end else begin
				px[p] = rgb(pick_sample(top), pick_sample(top), pick_sample(top));
			end
		end
		return quad(px[0], px[1], px[2], px[3]);
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_max(input logic [FW-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		book.set_max(v);
		settings_used++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_block(input rbty_pkg::pix_word_t w);
		bit took;
		pix_if.valid <= 1'b1;
		pix_if.word <= w;
		do begin
			@(negedge clk);
			took = pix_if.ready;
			@(posedge clk);
		end while (!took);
		blocks_sent++;
		if (!calm && sender_rests && $urandom_range(0, 3) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic run_phase(input logic [FW-1:0] max_val, input int n_rand,
		input bit with_hold, input bit with_pause);
		write_max(max_val);
		sender_rests = !with_hold;
		while (dir_q.size() != 0)
			send_block(dir_q.pop_front());
		if (with_hold)
			hold_req = 1;
		for (int i = 0; i < n_rand; i++) begin
			if (with_pause && i == n_rand / 2) begin
				pix_if.valid <= 1'b0;
				wait_drained();
			end
			send_block(random_block(max_val));
		end
		pix_if.valid <= 1'b0;
		sender_rests = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pix_if.valid = 1'b0;
		pix_if.word = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// primaries, secondaries, white, black, samples above the maximum
		dir_q.push_back(flat(16'd0));
		dir_q.push_back(flat(16'd255));
		dir_q.push_back(flat(16'hFFFF));
		dir_q.push_back(quad(rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
			rgb(255, 255, 255)));
		dir_q.push_back(quad(rgb(0, 255, 255), rgb(255, 0, 255), rgb(255, 255, 0),
			rgb(128, 128, 128)));
		dir_q.push_back(quad(rgb(16'hFFFF, 0, 0), rgb(0, 16'hFFFF, 0), rgb(0, 0, 16'hFFFF),
			rgb(256, 256, 256)));
		dir_q.push_back(quad(rgb(0, 16'hFFFF, 16'hFFFF), rgb(16'hFFFF, 16'hFFFF, 0),
			rgb(16'hFFFF, 0, 16'hFFFF), rgb(1, 1, 1)));
		dir_q.push_back(flat(16'hAAAA));
		dir_q.push_back(flat(16'h5555));
		dir_q.push_back(quad(rgb(1, 0, 0), rgb(0, 1, 0), rgb(0, 0, 1), rgb(254, 254, 254)));
		dir_q.push_back(flat(16'h8000));
		dir_q.push_back(flat(16'h7FFF));
		run_phase(16'd255, 70, 0, 1);

		// zero maximum acts as one
		dir_q.push_back(flat(16'd0));
		dir_q.push_back(flat(16'd1));
		dir_q.push_back(flat(16'd2));
		dir_q.push_back(quad(rgb(1, 0, 0), rgb(0, 1, 0), rgb(0, 0, 1), rgb(0, 1, 1)));
		run_phase(16'd0, 40, 0, 0);

		run_phase(16'd1, 40, 0, 0);

		dir_q.push_back(flat(16'hFFFF));
		dir_q.push_back(flat(16'h8000));
		dir_q.push_back(quad(rgb(16'hFFFF, 0, 0), rgb(0, 16'hFFFF, 0), rgb(0, 0, 16'hFFFF),
			rgb(1, 1, 1)));
		run_phase(16'hFFFF, 80, 1, 0);

		run_phase(16'd1023, 70, 0, 0);
		run_phase(16'($urandom_range(2, 65534)), 70, 0, 0);

		calm = 1;
		run_phase(16'd255, 60, 0, 0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixel blocks across %0d sample_max settings",
			blocks_sent, settings_used);
		$display("(0, 1, 255, 1023, 65535, random).");
		$display("Checked %0d output words, %0d long output hold-off(s), %0d mismatches.",
			book.words_checked, holds_done, book.mismatches);
		if (book.mismatches == 0 && book.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
